@@ src/ddd_pkg.sv @@
// Shared types, widths and calendar tables for the date difference block.
package ddd_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned DayNumW  = 22;
  localparam int unsigned DiffW    = 23;
  localparam int unsigned YearMax  = 9999;
  localparam int unsigned Latency  = 5;

  // Day number of one date plus its legality flag.
  typedef struct packed {
    logic               legal;
    logic [DayNumW-1:0] num;
  } ddd_date_t;

  // Length of a month; zero for codes that are not months.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months of a common year that come before month m.
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ src/ddd_date_conv.sv @@
// Three-stage pipeline that checks one date and turns it into a day number.
module ddd_date_conv
  import ddd_pkg::*;
(
  input  logic              clk_i,
  input  logic [YearW-1:0]  year_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output ddd_date_t         date_o
);

  // Stage 1: year divided by 100 through a reciprocal multiply.
  logic [YearW-1:0]  y1_q;
  logic [MonthW-1:0] m1_q;
  logic [DayW-1:0]   d1_q;
  logic [7:0]        qy1_q, qy1_d;
  logic              ok1_q, ok1_d;
  logic [26:0]       prod1;

  // Exact for every 14-bit year: floor(y * 5243 / 2^19) == floor(y / 100).
  assign prod1 = {13'd0, year_i} * 27'd5243;
  assign qy1_d = prod1[26:19];
  assign ok1_d = (year_i != '0) && (year_i <= YearW'(YearMax)) &&
                 (month_i != '0) && (month_i <= 4'd12) && (day_i != '0);

  always_ff @(posedge clk_i) begin
    y1_q  <= year_i;
    m1_q  <= month_i;
    d1_q  <= day_i;
    qy1_q <= qy1_d;
    ok1_q <= ok1_d;
  end

  // Stage 2: leap rule, day range check, and floor((y - 1) / 100).
  logic [YearW-1:0]  p2_q;
  logic [MonthW-1:0] m2_q;
  logic [DayW-1:0]   d2_q;
  logic [7:0]        c2_q, c2_d;
  logic              leap2_q, leap2_d;
  logic              legal2_q, legal2_d;
  logic [YearW-1:0]  hund;
  logic              cent;

  assign hund     = YearW'({6'd0, qy1_q} * 14'd100);
  assign cent     = (hund == y1_q);
  assign leap2_d  = cent ? (qy1_q[1:0] == 2'b00) : (y1_q[1:0] == 2'b00);
  assign legal2_d = ok1_q && (d1_q <= month_days(m1_q, leap2_d));
  // A year that is a whole century belongs to the previous century once 1 is taken off.
  assign c2_d     = qy1_q - {7'd0, cent};

  always_ff @(posedge clk_i) begin
    p2_q     <= y1_q - 14'd1;
    m2_q     <= m1_q;
    d2_q     <= d1_q;
    c2_q     <= c2_d;
    leap2_q  <= leap2_d;
    legal2_q <= legal2_d;
  end

  // Stage 3: closed-form day number, with 0001-01-01 as day zero.
  ddd_date_t      date_q, date_d;
  logic [DiffW-1:0] sum3;

  assign sum3 = DiffW'({9'd0, p2_q} * 23'd365)
              + DiffW'(p2_q >> 2)
              - DiffW'(c2_q)
              + DiffW'(c2_q >> 2)
              + DiffW'(days_before(m2_q))
              + DiffW'(leap2_q && (m2_q > 4'd2))
              + DiffW'(d2_q)
              - DiffW'(1);

  assign date_d.legal = legal2_q;
  assign date_d.num   = sum3[DayNumW-1:0];

  always_ff @(posedge clk_i) begin
    date_q <= date_d;
  end

  assign date_o = date_q;

endmodule

@@ src/date_difference_days_top.sv @@
// Top level: input register, two date converters and the final subtraction.
//
//  port group         direction  handshake              contents
//  request            in         start_i, busy_o        end and start year/month/day
//  result             out        done_o (one cycle)     day_difference_o, end_valid_o,
//                                                       start_valid_o
//
// A request is taken at every clock edge with start_i high and busy_o low.
// Its result passes through the request register, the three converter stages
// and the subtraction stage, and is taken at the edge on which done_o is high.
// A new request may enter every cycle while busy_o is low, so one result can leave every cycle.
// busy_o is high in reset and until busy_q clears after it; it never rises again.
// The receiver must take every result as it appears; the block does not enforce it.
module date_difference_days_top
  import ddd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [YearW-1:0]  end_year_i,
  input  logic [MonthW-1:0] end_month_i,
  input  logic [DayW-1:0]   end_day_i,
  input  logic [YearW-1:0]  start_year_i,
  input  logic [MonthW-1:0] start_month_i,
  input  logic [DayW-1:0]   start_day_i,
  output logic              done_o,
  output logic signed [DiffW-1:0] day_difference_o,
  output logic              end_valid_o,
  output logic              start_valid_o
);

  logic busy_q;
  logic accept;
  logic [Latency-1:0] vld_q, vld_d;

  assign accept = start_i && !busy_q;
  assign vld_d  = {vld_q[Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= vld_d;
    end
  end

  // Request register.
  logic [YearW-1:0]  ey_q, sy_q;
  logic [MonthW-1:0] em_q, sm_q;
  logic [DayW-1:0]   ed_q, sd_q;

  always_ff @(posedge clk_i) begin
    ey_q <= end_year_i;
    em_q <= end_month_i;
    ed_q <= end_day_i;
    sy_q <= start_year_i;
    sm_q <= start_month_i;
    sd_q <= start_day_i;
  end

  ddd_date_t end_date, start_date;

  ddd_date_conv u_end_conv (
    .clk_i   (clk_i),
    .year_i  (ey_q),
    .month_i (em_q),
    .day_i   (ed_q),
    .date_o  (end_date)
  );

  ddd_date_conv u_start_conv (
    .clk_i   (clk_i),
    .year_i  (sy_q),
    .month_i (sm_q),
    .day_i   (sd_q),
    .date_o  (start_date)
  );

  // Result stage: the difference is forced to zero unless both dates are legal.
  logic [DiffW-1:0] diff_q, diff_d;
  logic             ev_q, sv_q;

  assign diff_d = (end_date.legal && start_date.legal) ?
                  ({1'b0, end_date.num} - {1'b0, start_date.num}) : '0;

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    ev_q   <= end_date.legal;
    sv_q   <= start_date.legal;
  end

  assign busy_o           = busy_q;
  assign done_o           = vld_q[Latency-1];
  assign day_difference_o = diff_q;
  assign end_valid_o      = ev_q;
  assign start_valid_o    = sv_q;

  // Every accepted request comes out exactly after the pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("result strobe missing after request");

  // An illegal date always gives a zero difference.
  a_zero_if_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (!end_valid_o || !start_valid_o)) |-> (day_difference_o == '0))
    else $error("nonzero difference with an illegal date");

  // Two equal dates give a zero difference.
  a_equal_dates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start_i && !busy_o && (end_year_i == start_year_i) &&
           (end_month_i == start_month_i) && (end_day_i == start_day_i), 5) &&
     done_o) |-> (day_difference_o == '0))
    else $error("nonzero difference for equal dates");

endmodule

@@ verif/tb.sv @@
// Testbench for the date difference block: scoreboard, request driver and result checker.
`timescale 1ns / 1ps

module tb
  import ddd_pkg::*;
();

  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned RandomReqs = 2000;
  localparam int unsigned MaxReports = 100;
  localparam int unsigned MonthFeb   = 2;
  localparam int unsigned MonthDec   = 12;

  typedef struct {
    logic signed [DiffW-1:0] diff;
    logic                    end_ok;
    logic                    start_ok;
  } span_t;

  // Predicts the day span for each accepted request and checks results in order.
  class day_span_scoreboard;
    span_t       span_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        MonthFeb:              return is_leap(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    function bit is_legal(int unsigned y, int unsigned m, int unsigned d);
      if (y < 1 || y > YearMax || m < 1 || m > MonthDec || d < 1) return 1'b0;
      return d <= month_length(y, m);
    endfunction

    // Days elapsed since the first of January of year one.
    function int day_count(int unsigned y, int unsigned m, int unsigned d);
      int unsigned p;
      int          n;
      p = y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      for (int unsigned k = 1; k < m; k++) n += month_length(y, k);
      return n + d - 1;
    endfunction

    function void note_request(logic [YearW-1:0] ey, logic [MonthW-1:0] em,
                               logic [DayW-1:0] ed, logic [YearW-1:0] sy,
                               logic [MonthW-1:0] sm, logic [DayW-1:0] sd);
      span_t s;
      int    span;
      s.end_ok   = is_legal(ey, em, ed);
      s.start_ok = is_legal(sy, sm, sd);
      span = 0;
      if (s.end_ok && s.start_ok) span = day_count(ey, em, ed) - day_count(sy, sm, sd);
      s.diff = span[DiffW-1:0];
      span_q.push_back(s);
    endfunction

    task report(string msg);
      if (errors < MaxReports) $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [DiffW-1:0] diff, logic end_ok, logic start_ok);
      span_t s;
      if (span_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      s = span_q.pop_front();
      if (diff !== s.diff)
        report($sformatf("day_difference %0d, predicted %0d", diff, s.diff));
      if (end_ok !== s.end_ok)
        report($sformatf("end_valid %b, predicted %b", end_ok, s.end_ok));
      if (start_ok !== s.start_ok)
        report($sformatf("start_valid %b, predicted %b", start_ok, s.start_ok));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic [YearW-1:0]  end_year_i    = '0;
  logic [MonthW-1:0] end_month_i   = '0;
  logic [DayW-1:0]   end_day_i     = '0;
  logic [YearW-1:0]  start_year_i  = '0;
  logic [MonthW-1:0] start_month_i = '0;
  logic [DayW-1:0]   start_day_i   = '0;
  logic              busy_o;
  logic              done_o;
  logic signed [DiffW-1:0] day_difference_o;
  logic              end_valid_o;
  logic              start_valid_o;

  day_span_scoreboard sb = new();
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left  = 0;

  date_difference_days_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .end_year_i       (end_year_i),
    .end_month_i      (end_month_i),
    .end_day_i        (end_day_i),
    .start_year_i     (start_year_i),
    .start_month_i    (start_month_i),
    .start_day_i      (start_day_i),
    .done_o           (done_o),
    .day_difference_o (day_difference_o),
    .end_valid_o      (end_valid_o),
    .start_valid_o    (start_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Requests are noted before results are checked, on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_request(end_year_i, end_month_i, end_day_i,
                        start_year_i, start_month_i, start_day_i);
      if (done_o) sb.check_result(day_difference_o, end_valid_o, start_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back to back, some short gaps, a few long ones, and occasional
  // bursts with no gaps at all.
  function int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task send_request(int unsigned ey, int unsigned em, int unsigned ed,
                    int unsigned sy, int unsigned sm, int unsigned sd);
    int unsigned gap;
    start_i       <= 1'b1;
    end_year_i    <= ey[YearW-1:0];
    end_month_i   <= em[MonthW-1:0];
    end_day_i     <= ed[DayW-1:0];
    start_year_i  <= sy[YearW-1:0];
    start_month_i <= sm[MonthW-1:0];
    start_day_i   <= sd[DayW-1:0];
    do @(posedge clk_i); while (busy_o);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function void legal_date(int unsigned ylo, int unsigned yhi, output int unsigned y,
                           output int unsigned m, output int unsigned d);
    y = $urandom_range(ylo, yhi);
    m = $urandom_range(1, MonthDec);
    d = $urandom_range(1, sb.month_length(y, m));
  endfunction

  function void noise_date(output int unsigned y, output int unsigned m,
                           output int unsigned d);
    y = $urandom_range(0, (1 << YearW) - 1);
    m = $urandom_range(0, (1 << MonthW) - 1);
    d = $urandom_range(0, (1 << DayW) - 1);
  endfunction

  task send_random();
    int unsigned ey, em, ed, sy, sm, sd, r;
    r = $urandom_range(0, 99);
    legal_date(1, YearMax, ey, em, ed);
    if (r < 65) begin
      legal_date(1, YearMax, sy, sm, sd);
    end else if (r < 80) begin
      // Nearby dates exercise month and year boundaries.
      legal_date((ey > 1) ? ey - 1 : 1, (ey < YearMax) ? ey + 1 : YearMax, sy, sm, sd);
    end else if (r < 87) begin
      legal_date(1, 3, sy, sm, sd);
      legal_date(YearMax - 2, YearMax, ey, em, ed);
      if (r[0]) begin
        {ey, sy} = {sy, ey};
        {em, sm} = {sm, em};
        {ed, sd} = {sd, ed};
      end
    end else if (r < 93) begin
      noise_date(sy, sm, sd);
    end else begin
      noise_date(ey, em, ed);
      noise_date(sy, sm, sd);
    end
    send_request(ey, em, ed, sy, sm, sd);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(1, 1, 1, 1, 1, 1);
    send_request(9999, 12, 31, 1, 1, 1);
    send_request(1, 1, 1, 9999, 12, 31);
    send_request(2000, 2, 29, 2000, 3, 1);
    send_request(2024, 2, 29, 2023, 12, 31);
    send_request(1900, 2, 29, 1900, 2, 28);
    send_request(2023, 2, 28, 2023, 2, 29);
    send_request(2001, 1, 1, 2000, 12, 31);
    send_request(0, 6, 15, 2020, 6, 15);
    send_request(2020, 6, 15, 10000, 6, 15);
    send_request(16383, 15, 31, 1, 1, 1);
    send_request(2020, 0, 10, 2020, 13, 10);
    send_request(2020, 5, 10, 2020, 15, 10);
    send_request(2020, 4, 31, 2020, 4, 30);
    send_request(2020, 5, 0, 2020, 5, 31);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(2100, 2, 29, 2400, 2, 29);
    send_request(2400, 3, 1, 2100, 3, 1);
    send_request(4, 2, 29, 8191, 10, 16);
    send_request(5461, 11, 21, 10922, 5, 10);

    repeat (RandomReqs) send_random();

    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.span_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
